/* design/assert_macros.svh */
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EHT_ASSERT_IMPL(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication, checked during reset too.
`define EHT_ASSERT_NEXT(lbl, clk, a, c) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("assertion failed");

`endif

/* design/ehash_pkg.sv */
package ehash_pkg;

    localparam int SLOTS_DEF      = 8;
    localparam int MAX_DEPTH_DEF  = 10;
    localparam int BLOCKS_DEF     = 256;
    localparam int INIT_DEPTH_DEF = 0;

    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 64;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DEL_MISS = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 3'd6;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR_RD,
        S_BLK_RD,
        S_META,
        S_SCAN,
        S_DECIDE,
        S_SPLIT,
        S_SP_WB0,
        S_SP_WB1,
        S_CHUNK,
        S_DBL_RD,
        S_DBL_W0,
        S_DBL_W1,
        S_DBL_FIN,
        S_OUT
    } state_t;

endpackage

/* design/ehash_ram.sv */
module ehash_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/extendible_hash_table.sv */
// Extendible hash key-value engine.
// Requests enter on the s_ channel (s_op, s_key, s_key_hash, s_value) under
// s_valid/s_ready; one result per request leaves on the m_ channel
// (m_status, m_read_value, m_current_depth) under m_valid/m_ready.
// The block works on one request at a time. A lookup, delete, update or
// insert into a block with room passes the directory read, the metadata read,
// a slot scan through the single slot memory read port and the decision.
// Each split adds the split scan, two metadata writes and the retried
// directory read and slot scan, plus a directory pass: half a chunk of
// entries at one a cycle, or, when the directory doubles, a read and two
// writes per old entry and a final write of the new block's entry.
// After reset a clearing pass over max(BLOCKS, 2^INIT_DEPTH) rows
// initializes block metadata and the directory; s_ready stays low during it.
// A finished result waits in the output register while the receiver stalls;
// the next request is accepted meanwhile, and its result is held back until
// the previous one has been taken.
module extendible_hash_table #(
    parameter int SLOTS      = ehash_pkg::SLOTS_DEF,
    parameter int MAX_DEPTH  = ehash_pkg::MAX_DEPTH_DEF,
    parameter int BLOCKS     = ehash_pkg::BLOCKS_DEF,
    parameter int INIT_DEPTH = ehash_pkg::INIT_DEPTH_DEF,
    parameter int DW         = $clog2(MAX_DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ehash_pkg::OP_W-1:0]    s_op,
    input  logic [ehash_pkg::KEY_W-1:0]   s_key,
    input  logic [MAX_DEPTH-1:0]          s_key_hash,
    input  logic [ehash_pkg::VALUE_W-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ehash_pkg::STATUS_W-1:0] m_status,
    output logic [ehash_pkg::VALUE_W-1:0] m_read_value,
    output logic [DW-1:0]                 m_current_depth
);

    localparam int KW       = ehash_pkg::KEY_W;
    localparam int VW       = ehash_pkg::VALUE_W;
    localparam int HW       = MAX_DEPTH;
    localparam int BW       = $clog2(BLOCKS);
    localparam int AW       = $clog2(BLOCKS * SLOTS);
    localparam int SCW      = $clog2(SLOTS + 1);
    localparam int SIW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int INIT_N   = 2 ** INIT_DEPTH;
    localparam int CLR_ROWS = (BLOCKS > INIT_N) ? BLOCKS : INIT_N;
    localparam int CW       = $clog2(CLR_ROWS + 1);
    localparam int SDW      = KW + VW + HW;
    localparam int MDW      = SLOTS + DW;

    ehash_pkg::state_t state_reg, state_next;

    logic [CW-1:0]        clr_reg, clr_next;
    logic [BW-1:0]        clr_mod_reg, clr_mod_next;
    logic [ehash_pkg::OP_W-1:0] op_reg, op_next;
    logic [KW-1:0]        key_reg, key_next;
    logic [HW-1:0]        hash_reg, hash_next;
    logic [VW-1:0]        value_reg, value_next;
    logic [DW-1:0]        dd_reg, dd_next;
    logic [CW-1:0]        nfb_reg, nfb_next;
    logic [BW-1:0]        b_reg, b_next;
    logic [SLOTS-1:0]     mask_reg, mask_next;
    logic [DW-1:0]        ld_reg, ld_next;
    logic [SCW-1:0]       cnt_reg, cnt_next;
    logic                 found_reg, found_next;
    logic [SCW-1:0]       fidx_reg, fidx_next;
    logic [VW-1:0]        fval_reg, fval_next;
    logic [HW-1:0]        fhash_reg, fhash_next;
    logic                 free_reg, free_next;
    logic [SCW-1:0]       free_idx_reg, free_idx_next;
    logic [BW-1:0]        nb_reg, nb_next;
    logic [SCW-1:0]       n_reg, n_next;
    logic [SLOTS-1:0]     nmask_reg, nmask_next;
    logic [HW:0]          ci_reg, ci_next;
    logic [HW:0]          ce_reg, ce_next;
    logic [HW-1:0]        base_reg, base_next;
    logic [HW-1:0]        di_reg, di_next;
    logic [BW-1:0]        v_reg, v_next;
    logic [ehash_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [VW-1:0]        res_rv_reg, res_rv_next;
    logic                 m_valid_reg, m_valid_next;
    logic [ehash_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [VW-1:0]        m_rv_reg, m_rv_next;
    logic [DW-1:0]        m_depth_reg, m_depth_next;

    logic            dir_we;
    logic [HW-1:0]   dir_waddr, dir_raddr;
    logic [BW-1:0]   dir_wdata, dir_rdata;
    logic            blk_we;
    logic [BW-1:0]   blk_waddr, blk_raddr;
    logic [MDW-1:0]  blk_wdata, blk_rdata;
    logic            slot_we;
    logic [AW-1:0]   slot_waddr, slot_raddr;
    logic [SDW-1:0]  slot_wdata, slot_rdata;

    logic [KW-1:0]   slot_rkey;
    logic [VW-1:0]   slot_rval;
    logic [HW-1:0]   slot_rhash;
    logic [HW-1:0]   x_idx;
    logic [AW-1:0]   slot_base, nb_base;
    logic [SCW-1:0]  sidx;
    logic [SIW-1:0]  sbit;
    logic            hsel;
    logic            smask;

    ehash_ram #(.DEPTH(2 ** MAX_DEPTH), .WIDTH(BW), .AW(HW)) u_dir (
        .aclk(aclk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
        .raddr(dir_raddr), .rdata(dir_rdata)
    );

    ehash_ram #(.DEPTH(BLOCKS), .WIDTH(MDW), .AW(BW)) u_blk (
        .aclk(aclk), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
        .raddr(blk_raddr), .rdata(blk_rdata)
    );

    ehash_ram #(.DEPTH(BLOCKS * SLOTS), .WIDTH(SDW), .AW(AW)) u_slot (
        .aclk(aclk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_raddr), .rdata(slot_rdata)
    );

    assign slot_rkey  = slot_rdata[SDW-1 -: KW];
    assign slot_rval  = slot_rdata[HW +: VW];
    assign slot_rhash = slot_rdata[HW-1:0];

    assign x_idx     = HW'(hash_reg >> (MAX_DEPTH - int'(dd_reg)));
    assign slot_base = AW'(AW'(b_reg) * AW'(SLOTS));
    assign nb_base   = AW'(AW'(nb_reg) * AW'(SLOTS));
    assign sidx      = cnt_reg - SCW'(1);
    assign sbit      = SIW'(sidx);
    assign smask     = mask_reg[sbit];
    assign hsel      = |(slot_rhash & (HW'(1) << (MAX_DEPTH - 1 - int'(ld_reg))));

    assign s_ready         = (state_reg == ehash_pkg::S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_read_value    = m_rv_reg;
    assign m_current_depth = m_depth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ehash_pkg::S_CLEAR;
            clr_reg     <= '0;
            clr_mod_reg <= '0;
            dd_reg      <= DW'(INIT_DEPTH);
            nfb_reg     <= CW'(INIT_N);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            clr_mod_reg <= clr_mod_next;
            dd_reg      <= dd_next;
            nfb_reg     <= nfb_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        hash_reg       <= hash_next;
        value_reg      <= value_next;
        b_reg          <= b_next;
        mask_reg       <= mask_next;
        ld_reg         <= ld_next;
        cnt_reg        <= cnt_next;
        found_reg      <= found_next;
        fidx_reg       <= fidx_next;
        fval_reg       <= fval_next;
        fhash_reg      <= fhash_next;
        free_reg       <= free_next;
        free_idx_reg   <= free_idx_next;
        nb_reg         <= nb_next;
        n_reg          <= n_next;
        nmask_reg      <= nmask_next;
        ci_reg         <= ci_next;
        ce_reg         <= ce_next;
        base_reg       <= base_next;
        di_reg         <= di_next;
        v_reg          <= v_next;
        res_status_reg <= res_status_next;
        res_rv_reg     <= res_rv_next;
        m_status_reg   <= m_status_next;
        m_rv_reg       <= m_rv_next;
        m_depth_reg    <= m_depth_next;
    end

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        clr_mod_next    = clr_mod_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        hash_next       = hash_reg;
        value_next      = value_reg;
        dd_next         = dd_reg;
        nfb_next        = nfb_reg;
        b_next          = b_reg;
        mask_next       = mask_reg;
        ld_next         = ld_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        fidx_next       = fidx_reg;
        fval_next       = fval_reg;
        fhash_next      = fhash_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        nb_next         = nb_reg;
        n_next          = n_reg;
        nmask_next      = nmask_reg;
        ci_next         = ci_reg;
        ce_next         = ce_reg;
        base_next       = base_reg;
        di_next         = di_reg;
        v_next          = v_reg;
        res_status_next = res_status_reg;
        res_rv_next     = res_rv_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_rv_next       = m_rv_reg;
        m_depth_next    = m_depth_reg;

        dir_we     = 1'b0;
        dir_waddr  = '0;
        dir_wdata  = '0;
        dir_raddr  = x_idx;
        blk_we     = 1'b0;
        blk_waddr  = b_reg;
        blk_wdata  = '0;
        blk_raddr  = b_reg;
        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        slot_raddr = AW'(slot_base + AW'(cnt_reg));

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ehash_pkg::S_CLEAR: begin
                blk_we    = (clr_reg < CW'(BLOCKS));
                blk_waddr = BW'(clr_reg);
                blk_wdata = {{SLOTS{1'b0}}, DW'(INIT_DEPTH)};
                dir_we    = (clr_reg < CW'(INIT_N));
                dir_waddr = HW'(clr_reg);
                dir_wdata = clr_mod_reg;
                clr_mod_next = (clr_mod_reg == BW'(BLOCKS - 1)) ? '0 : clr_mod_reg + BW'(1);
                clr_next = clr_reg + CW'(1);
                if (clr_reg == CW'(CLR_ROWS - 1)) begin
                    state_next = ehash_pkg::S_IDLE;
                end
            end
            ehash_pkg::S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_op;
                    key_next   = s_key;
                    hash_next  = s_key_hash;
                    value_next = s_value;
                    state_next = ehash_pkg::S_DIR_RD;
                end
            end
            ehash_pkg::S_DIR_RD: begin
                state_next = ehash_pkg::S_BLK_RD;
            end
            ehash_pkg::S_BLK_RD: begin
                b_next     = dir_rdata;
                blk_raddr  = dir_rdata;
                state_next = ehash_pkg::S_META;
            end
            ehash_pkg::S_META: begin
                mask_next  = blk_rdata[MDW-1 -: SLOTS];
                ld_next    = blk_rdata[DW-1:0];
                cnt_next   = '0;
                found_next = 1'b0;
                free_next  = 1'b0;
                state_next = ehash_pkg::S_SCAN;
            end
            ehash_pkg::S_SCAN: begin
                if (cnt_reg != '0) begin
                    if (smask && (slot_rkey == key_reg) && !found_reg) begin
                        found_next = 1'b1;
                        fidx_next  = sidx;
                        fval_next  = slot_rval;
                        fhash_next = slot_rhash;
                    end
                    if (!smask && !free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = sidx;
                    end
                end
                if (cnt_reg == SCW'(SLOTS)) begin
                    state_next = ehash_pkg::S_DECIDE;
                end else begin
                    cnt_next = cnt_reg + SCW'(1);
                end
            end
            ehash_pkg::S_DECIDE: begin
                res_rv_next = '0;
                state_next  = ehash_pkg::S_OUT;
                case (op_reg)
                    ehash_pkg::OP_INSERT: begin
                        if (found_reg) begin
                            slot_we    = 1'b1;
                            slot_waddr = AW'(slot_base + AW'(fidx_reg));
                            slot_wdata = {key_reg, value_reg, fhash_reg};
                            res_status_next = ehash_pkg::ST_UPDATED;
                        end else if (free_reg) begin
                            slot_we    = 1'b1;
                            slot_waddr = AW'(slot_base + AW'(free_idx_reg));
                            slot_wdata = {key_reg, value_reg, hash_reg};
                            blk_we     = 1'b1;
                            blk_wdata  = {mask_reg | (SLOTS'(1) << SIW'(free_idx_reg)),
                                          ld_reg};
                            res_status_next = ehash_pkg::ST_INSERTED;
                        end else if ((ld_reg >= DW'(MAX_DEPTH)) ||
                                     (nfb_reg >= CW'(BLOCKS))) begin
                            res_status_next = ehash_pkg::ST_NO_ROOM;
                        end else begin
                            nb_next    = BW'(nfb_reg);
                            nfb_next   = nfb_reg + CW'(1);
                            cnt_next   = '0;
                            n_next     = '0;
                            nmask_next = '0;
                            state_next = ehash_pkg::S_SPLIT;
                        end
                    end
                    ehash_pkg::OP_DELETE: begin
                        if (found_reg) begin
                            blk_we    = 1'b1;
                            blk_wdata = {mask_reg & ~(SLOTS'(1) << SIW'(fidx_reg)), ld_reg};
                            res_status_next = ehash_pkg::ST_DELETED;
                        end else begin
                            res_status_next = ehash_pkg::ST_DEL_MISS;
                        end
                    end
                    default: begin
                        if (found_reg) begin
                            res_rv_next     = fval_reg;
                            res_status_next = ehash_pkg::ST_HIT;
                        end else begin
                            res_status_next = ehash_pkg::ST_MISS;
                        end
                    end
                endcase
            end
            ehash_pkg::S_SPLIT: begin
                if ((cnt_reg != '0) && smask && hsel) begin
                    slot_we    = 1'b1;
                    slot_waddr = AW'(nb_base + AW'(n_reg));
                    slot_wdata = slot_rdata;
                    n_next     = n_reg + SCW'(1);
                    nmask_next = nmask_reg | (SLOTS'(1) << n_reg);
                    mask_next  = mask_reg & ~(SLOTS'(1) << sbit);
                end
                if (cnt_reg == SCW'(SLOTS)) begin
                    state_next = ehash_pkg::S_SP_WB0;
                end else begin
                    cnt_next = cnt_reg + SCW'(1);
                end
            end
            ehash_pkg::S_SP_WB0: begin
                blk_we     = 1'b1;
                blk_wdata  = {mask_reg, ld_reg + DW'(1)};
                state_next = ehash_pkg::S_SP_WB1;
            end
            ehash_pkg::S_SP_WB1: begin
                blk_we    = 1'b1;
                blk_waddr = nb_reg;
                blk_wdata = {nmask_reg, ld_reg + DW'(1)};
                if (ld_reg < dd_reg) begin
                    ce_next    = (HW + 1)'(1) << (dd_reg - ld_reg);
                    ci_next    = ((HW + 1)'(1) << (dd_reg - ld_reg)) >> 1;
                    base_next  = x_idx & ~(HW'((HW + 1)'(1) << (dd_reg - ld_reg)) - HW'(1));
                    state_next = ehash_pkg::S_CHUNK;
                end else begin
                    di_next    = HW'(((HW + 1)'(1) << dd_reg) - (HW + 1)'(1));
                    state_next = ehash_pkg::S_DBL_RD;
                end
            end
            ehash_pkg::S_CHUNK: begin
                dir_we    = 1'b1;
                dir_waddr = HW'(base_reg + HW'(ci_reg));
                dir_wdata = nb_reg;
                ci_next   = ci_reg + (HW + 1)'(1);
                if (ci_reg == ce_reg - (HW + 1)'(1)) begin
                    state_next = ehash_pkg::S_DIR_RD;
                end
            end
            ehash_pkg::S_DBL_RD: begin
                dir_raddr  = di_reg;
                state_next = ehash_pkg::S_DBL_W0;
            end
            ehash_pkg::S_DBL_W0: begin
                dir_we     = 1'b1;
                dir_waddr  = HW'(di_reg << 1);
                dir_wdata  = dir_rdata;
                v_next     = dir_rdata;
                state_next = ehash_pkg::S_DBL_W1;
            end
            ehash_pkg::S_DBL_W1: begin
                dir_we    = 1'b1;
                dir_waddr = HW'(di_reg << 1) + HW'(1);
                dir_wdata = v_reg;
                if (di_reg == '0) begin
                    state_next = ehash_pkg::S_DBL_FIN;
                end else begin
                    di_next    = di_reg - HW'(1);
                    state_next = ehash_pkg::S_DBL_RD;
                end
            end
            ehash_pkg::S_DBL_FIN: begin
                dir_we     = 1'b1;
                dir_waddr  = HW'(x_idx << 1) + HW'(1);
                dir_wdata  = nb_reg;
                dd_next    = dd_reg + DW'(1);
                state_next = ehash_pkg::S_DIR_RD;
            end
            ehash_pkg::S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_rv_next     = res_rv_reg;
                    m_depth_next  = dd_reg;
                    state_next    = ehash_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ehash_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* design/ehash_checker.sv */
`include "assert_macros.svh"

module ehash_checker #(
    parameter int MAX_DEPTH = ehash_pkg::MAX_DEPTH_DEF,
    parameter int DW        = $clog2(MAX_DEPTH + 1)
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [ehash_pkg::STATUS_W-1:0] m_status,
    input logic [ehash_pkg::VALUE_W-1:0]  m_read_value,
    input logic [DW-1:0]                  m_current_depth
);

    `EHT_ASSERT_NEXT(a_reset_clears, aclk, !aresetn, !m_valid)
    `EHT_ASSERT_NEXT(a_stall_holds, aclk, aresetn && m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_read_value))
    `EHT_ASSERT_IMPL(a_value_only_on_hit, aclk, aresetn, m_valid && (m_status != ehash_pkg::ST_HIT), m_read_value == '0)
    `EHT_ASSERT_IMPL(a_result_range, aclk, aresetn, m_valid, (m_status <= ehash_pkg::ST_NO_ROOM) && (m_current_depth <= DW'(MAX_DEPTH)))

endmodule

bind extendible_hash_table ehash_checker #(.MAX_DEPTH(MAX_DEPTH), .DW(DW)) u_ehash_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_status(m_status),
    .m_read_value(m_read_value),
    .m_current_depth(m_current_depth)
);

/* bench/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 8;
    localparam int MAXD = 10;
    localparam int NBLK = 256;
    localparam int DIRN = 1 << MAXD;
    localparam int WATCH_LIMIT = 40000;
    localparam logic [ehash_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [ehash_pkg::OP_W-1:0] op;
        logic [63:0] key;
        logic [MAXD-1:0] hash;
        logic [63:0] value;
    } request_t;

    typedef struct packed {
        logic [ehash_pkg::STATUS_W-1:0] status;
        logic [63:0] rdval;
        logic [3:0] depth;
    } answer_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [ehash_pkg::OP_W-1:0] s_op = '0;
    logic [63:0] s_key = '0;
    logic [MAXD-1:0] s_key_hash = '0;
    logic [63:0] s_value = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [ehash_pkg::STATUS_W-1:0] m_status;
    logic [63:0] m_read_value;
    logic [3:0] m_current_depth;

    extendible_hash_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_key(s_key),
        .s_key_hash(s_key_hash), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_read_value(m_read_value), .m_current_depth(m_current_depth)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Shadow copy of the table.
    int unsigned dir_tab[DIRN];
    logic [63:0] sh_key[NBLK*SLOTS];
    logic [63:0] sh_val[NBLK*SLOTS];
    logic [MAXD-1:0] sh_hash[NBLK*SLOTS];
    bit sh_valid[NBLK*SLOTS];
    int unsigned blk_depth[NBLK];
    int unsigned gdepth;
    int unsigned next_blk;

    request_t pending_reqs[$];
    answer_t expected_answers[$];
    int errors = 0;
    bit hold_off = 0;

    function automatic int unsigned dir_slot(logic [MAXD-1:0] h);
        return gdepth == 0 ? 0 : int'(h) >> (MAXD - gdepth);
    endfunction

    function automatic int find_key(int unsigned b, logic [63:0] k);
        for (int s = 0; s < SLOTS; s++)
            if (sh_valid[b*SLOTS+s] && sh_key[b*SLOTS+s] == k) return b*SLOTS + s;
        return -1;
    endfunction

    function automatic bit split_bucket(int unsigned b, logic [MAXD-1:0] h);
        int unsigned ld, nb, bitpos, n, x, chunk, base, v;
        ld = blk_depth[b];
        if (ld >= MAXD || next_blk >= NBLK) return 0;
        nb = next_blk;
        next_blk++;
        bitpos = MAXD - ld - 1;
        n = 0;
        for (int s = 0; s < SLOTS; s++) sh_valid[nb*SLOTS+s] = 0;
        for (int s = 0; s < SLOTS; s++) begin
            int unsigned i;
            i = b*SLOTS + s;
            if (sh_valid[i] && sh_hash[i][bitpos]) begin
                sh_key[nb*SLOTS+n] = sh_key[i];
                sh_val[nb*SLOTS+n] = sh_val[i];
                sh_hash[nb*SLOTS+n] = sh_hash[i];
                sh_valid[nb*SLOTS+n] = 1;
                sh_valid[i] = 0;
                n++;
            end
        end
        blk_depth[b] = ld + 1;
        blk_depth[nb] = ld + 1;
        x = dir_slot(h);
        if (ld < gdepth) begin
            chunk = 1 << (gdepth - ld);
            base = x & ~(chunk - 1);
            for (int i = chunk/2; i < chunk; i++) dir_tab[(base+i) % DIRN] = nb;
        end else begin
            for (int i = (1 << gdepth) - 1; i >= 0; i--) begin
                v = dir_tab[i];
                dir_tab[(2*i) % DIRN] = v;
                dir_tab[(2*i+1) % DIRN] = v;
            end
            dir_tab[(2*x+1) % DIRN] = nb;
            gdepth++;
        end
        return 1;
    endfunction

    function automatic answer_t predict_answer(request_t r);
        answer_t a;
        int i;
        int unsigned b;
        a = '0;
        if (r.op == ehash_pkg::OP_INSERT) begin
            forever begin
                b = dir_tab[dir_slot(r.hash)];
                i = find_key(b, r.key);
                if (i >= 0) begin
                    sh_val[i] = r.value;
                    a.status = ehash_pkg::ST_UPDATED;
                    break;
                end
                i = -1;
                for (int s = SLOTS - 1; s >= 0; s--) if (!sh_valid[b*SLOTS+s]) i = b*SLOTS + s;
                if (i >= 0) begin
                    sh_key[i] = r.key;
                    sh_val[i] = r.value;
                    sh_hash[i] = r.hash;
                    sh_valid[i] = 1;
                    a.status = ehash_pkg::ST_INSERTED;
                    break;
                end
                if (!split_bucket(b, r.hash)) begin
                    a.status = ehash_pkg::ST_NO_ROOM;
                    break;
                end
            end
        end else if (r.op == ehash_pkg::OP_DELETE) begin
            i = find_key(dir_tab[dir_slot(r.hash)], r.key);
            if (i >= 0) begin
                sh_valid[i] = 0;
                a.status = ehash_pkg::ST_DELETED;
            end else begin
                a.status = ehash_pkg::ST_DEL_MISS;
            end
        end else begin
            i = find_key(dir_tab[dir_slot(r.hash)], r.key);
            if (i >= 0) begin
                a.rdval = sh_val[i];
                a.status = ehash_pkg::ST_HIT;
            end else begin
                a.status = ehash_pkg::ST_MISS;
            end
        end
        a.depth = gdepth[3:0];
        return a;
    endfunction

    // Sender: bursts and gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_answers.push_back(predict_answer(
                    request_t'{s_op, s_key, s_key_hash, s_value}));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 0;
                end else if (pending_reqs.size() > 0) begin
                    request_t r;
                    r = pending_reqs.pop_front();
                    s_valid <= 1;
                    s_op <= r.op;
                    s_key <= r.key;
                    s_key_hash <= r.hash;
                    s_value <= r.value;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // Receiver: stall pattern plus one long hold-off.
    int rx_phase = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            rx_phase <= rx_phase + 1;
            if (hold_off) m_ready <= 0;
            else if (rx_phase[9:8] == 2'd0) m_ready <= 1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor and checker.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            answer_t want;
            if (expected_answers.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: status %0d", m_status);
            end else begin
                want = expected_answers.pop_front();
                if (m_status !== want.status || m_read_value !== want.rdval ||
                        m_current_depth !== want.depth) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d/%h/%0d got %0d/%h/%0d",
                            want.status, want.rdval, want.depth,
                            m_status, m_read_value, m_current_depth);
                end
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    logic [63:0] live_keys[$];
    logic [MAXD-1:0] live_hash[$];

    task automatic add_req(logic [ehash_pkg::OP_W-1:0] op, logic [63:0] k,
                           logic [MAXD-1:0] h, logic [63:0] v);
        pending_reqs.push_back(request_t'{op, k, h, v});
    endtask

    task automatic add_random(int n, int hash_bits);
        logic [63:0] k;
        logic [MAXD-1:0] h;
        int sel, idx;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 5 || live_keys.size() == 0) begin
                k = {$urandom, $urandom};
                h = MAXD'($urandom);
                if (hash_bits < MAXD)
                    h = MAXD'((h >> (MAXD - hash_bits) << (MAXD - hash_bits)) |
                        ($urandom_range(0, 1) ? (h & MAXD'(3)) : MAXD'(0)));
                if (sel < 5) begin
                    live_keys.push_back(k);
                    live_hash.push_back(h);
                end
                add_req(sel < 5 ? ehash_pkg::OP_INSERT : ehash_pkg::OP_LOOKUP, k, h,
                    {$urandom, $urandom});
            end else begin
                idx = $urandom_range(0, live_keys.size() - 1);
                k = live_keys[idx];
                h = live_hash[idx];
                if (sel == 9) begin
                    add_req(ehash_pkg::OP_DELETE, k, h, {$urandom, $urandom});
                    live_keys.delete(idx);
                    live_hash.delete(idx);
                end else begin
                    add_req(sel < 7 ? ehash_pkg::OP_LOOKUP :
                        (sel == 7 ? ehash_pkg::OP_INSERT : OP_UNUSED), k, h,
                        {$urandom, $urandom});
                end
            end
        end
    endtask

    initial begin
        for (int i = 0; i < DIRN; i++) dir_tab[i] = 0;
        for (int i = 0; i < NBLK*SLOTS; i++) sh_valid[i] = 0;
        for (int i = 0; i < NBLK; i++) blk_depth[i] = 0;
        gdepth = 0;
        next_blk = 1;

        add_req(ehash_pkg::OP_LOOKUP, 64'd0, '0, '0);
        add_req(ehash_pkg::OP_DELETE, '1, '1, '0);
        add_req(ehash_pkg::OP_INSERT, 64'd0, '0, '1);
        add_req(ehash_pkg::OP_INSERT, '1, '1, 64'd0);
        add_req(ehash_pkg::OP_LOOKUP, 64'd0, '0, '0);
        add_req(ehash_pkg::OP_LOOKUP, '1, '1, '0);
        add_req(OP_UNUSED, '1, '1, '1);
        add_req(ehash_pkg::OP_INSERT, '1, '1, 64'h5555_aaaa_5555_aaaa);
        add_req(ehash_pkg::OP_DELETE, 64'd0, '0, '0);
        add_req(ehash_pkg::OP_DELETE, 64'd0, '0, '0);
        // Identical hashes force repeated splits up to full depth and then no room.
        for (int i = 0; i < 10; i++)
            add_req(ehash_pkg::OP_INSERT, 64'h100 + 64'(i), 10'h155, 64'(i));
        add_req(ehash_pkg::OP_LOOKUP, 64'h109, 10'h155, '0);

        add_random(700, 4);
        add_random(840, MAXD);

        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
        join_none

        repeat (9) @(posedge aclk);
        aresetn <= 1;
        wait (pending_reqs.size() == 0 && !s_valid);
        wait (expected_answers.size() == 0);
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
